// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the buffer cache RTL.
// Each macro takes a label, the clock and the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define BBC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/bbc_pkg.sv =====
// Package for the block buffer cache tag table: sizes, opcodes, status codes
// and the slot entry type. No dependencies.
package bbc_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  localparam int OPCODE_W = 2;
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int SIDX_W   = 5;
  localparam int TICK_W   = 32;
  localparam int CNT_W    = 8;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_GET     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PIN     = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UNPIN   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [CNT_W-1:0]  cnt;
    logic [TICK_W-1:0] stamp;
    logic              valid;
  } slot_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    slot_entry_t       entry;
  } slot_wr_t;

endpackage

// ===== rtl/bbc_in_if.sv =====
// Request channel of the buffer cache: valid/ready plus the request fields.
// Depends on bbc_pkg.
interface bbc_in_if;
  import bbc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [DEV_W-1:0]    device;
  logic [BLK_W-1:0]    block_number;
  logic [SIDX_W-1:0]   slot_index;
  logic [TICK_W-1:0]   now_tick;

  modport source (output valid, opcode, device, block_number, slot_index, now_tick,
                  input ready);
  modport sink (input valid, opcode, device, block_number, slot_index, now_tick,
                output ready);
endinterface

// ===== rtl/bbc_out_if.sv =====
// Response channel of the buffer cache: valid/ready plus the result fields.
// Depends on bbc_pkg.
interface bbc_out_if;
  import bbc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SIDX_W-1:0]   granted_slot;
  logic                hit;
  logic                needs_fill;
  logic [STATUS_W-1:0] status;

  modport source (output valid, granted_slot, hit, needs_fill, status, input ready);
  modport sink (input valid, granted_slot, hit, needs_fill, status, output ready);
endinterface

// ===== rtl/block_buffer_cache_lru_top.sv =====
// Block buffer cache tag table with reference counts and LRU replacement.
// A get walks the slot store one slot per cycle through a single tag and age
// comparator and stops at the first hit; a miss scans all 32 slots. The
// update step then writes the store if needed and holds while the output stalls.
// Release, pin and unpin go from accept straight to one read-modify-write.
// The request channel is ready only while the sequencer is idle; the result
// sits in an output register, so the next request is taken while it waits.
// Depends on bbc_pkg, bbc_in_if, bbc_out_if, bbc_slot_store, assert_macros.svh.
`include "assert_macros.svh"

module block_buffer_cache_lru_top (
  input  logic       clk,
  input  logic       rst_n,
  bbc_in_if.sink     in_ch,
  bbc_out_if.source  out_ch
);
  import bbc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  logic [1:0]          state_r, state_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [DEV_W-1:0]    dev_r, dev_nxt;
  logic [BLK_W-1:0]    blk_r, blk_nxt;
  logic [SIDX_W-1:0]   sidx_r, sidx_nxt;
  logic [TICK_W-1:0]   now_r, now_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [SLOT_W-1:0]   tgt_r, tgt_nxt;
  logic [SLOT_W-1:0]   vic_r, vic_nxt;
  logic [TICK_W-1:0]   oldest_r, oldest_nxt;
  logic                found_r, found_nxt;
  logic                have_r, have_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SIDX_W-1:0]   out_slot_r, out_slot_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic                out_fill_r, out_fill_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                in_fire;
  logic                out_free;
  logic [SLOT_W-1:0]   rd_idx;
  slot_entry_t         rd_entry;
  slot_wr_t            wr;
  logic                tag_match;
  logic                older;
  logic                in_range;
  logic [CNT_W-1:0]    cnt_up;

  bbc_slot_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_fire             = in_ch.valid & in_ch.ready;
  assign out_free            = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted_slot = out_slot_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.needs_fill   = out_fill_r;
  assign out_ch.status       = out_status_r;

  // The comparator sees the scanned slot during the scan of a get, the target slot otherwise.
  assign rd_idx    = (state_r == S_SCAN) ? idx_r : tgt_r;
  assign tag_match = (rd_entry.dev == dev_r) && (rd_entry.blk == blk_r);
  assign older     = (rd_entry.cnt == '0) && (!have_r || (rd_entry.stamp < oldest_r));
  assign in_range  = (32'(sidx_r) < 32'(SLOT_COUNT));
  assign cnt_up    = (rd_entry.cnt == CNT_MAX) ? rd_entry.cnt : rd_entry.cnt + CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    dev_nxt        = dev_r;
    blk_nxt        = blk_r;
    sidx_nxt       = sidx_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    tgt_nxt        = tgt_r;
    vic_nxt        = vic_r;
    oldest_nxt     = oldest_r;
    found_nxt      = found_r;
    have_nxt       = have_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_slot_nxt   = out_slot_r;
    out_hit_nxt    = out_hit_r;
    out_fill_nxt   = out_fill_r;
    out_status_nxt = out_status_r;
    wr             = '0;
    wr.idx         = tgt_r;
    wr.entry       = rd_entry;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_ch.opcode;
          dev_nxt   = in_ch.device;
          blk_nxt   = in_ch.block_number;
          sidx_nxt  = in_ch.slot_index;
          now_nxt   = in_ch.now_tick;
          idx_nxt   = '0;
          tgt_nxt   = SLOT_W'(in_ch.slot_index);
          found_nxt = 1'b0;
          have_nxt  = 1'b0;
          state_nxt = (in_ch.opcode == OP_GET) ? S_SCAN : S_UPDATE;
        end
      end

      S_SCAN: begin
        if (tag_match) begin
          found_nxt = 1'b1;
          tgt_nxt   = idx_r;
          state_nxt = S_UPDATE;
        end else begin
          if (older) begin
            have_nxt   = 1'b1;
            vic_nxt    = idx_r;
            oldest_nxt = rd_entry.stamp;
          end
          if (idx_r == LAST_SLOT) begin
            tgt_nxt   = older ? idx_r : vic_r;
            state_nxt = S_UPDATE;
          end else begin
            idx_nxt = idx_r + SLOT_W'(1);
          end
        end
      end

      S_UPDATE: begin
        // The store is written in the same cycle the result is registered,
        // so a stalled output simply holds the sequencer here.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = 1'b0;
          out_fill_nxt   = 1'b0;
          out_status_nxt = ST_OK;
          out_slot_nxt   = SIDX_W'(tgt_r);
          state_nxt      = S_IDLE;
          if (op_r == OP_GET) begin
            if (found_r) begin
              wr.en             = 1'b1;
              wr.entry.cnt      = cnt_up;
              wr.entry.stamp    = now_r;
              wr.entry.valid    = 1'b1;
              out_hit_nxt       = 1'b1;
              out_fill_nxt      = !rd_entry.valid;
            end else if (have_r) begin
              wr.en             = 1'b1;
              wr.entry.dev      = dev_r;
              wr.entry.blk      = blk_r;
              wr.entry.cnt      = CNT_W'(1);
              wr.entry.stamp    = now_r;
              wr.entry.valid    = 1'b1;
              out_fill_nxt      = 1'b1;
            end else begin
              out_slot_nxt      = '0;
              out_status_nxt    = ST_NO_FREE;
            end
          end else begin
            out_slot_nxt = sidx_r;
            if (in_range) begin
              if (op_r == OP_PIN) begin
                wr.en        = 1'b1;
                wr.entry.cnt = cnt_up;
              end else if (rd_entry.cnt == '0) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                wr.en        = 1'b1;
                wr.entry.cnt = rd_entry.cnt - CNT_W'(1);
                if (op_r == OP_RELEASE) begin
                  wr.entry.stamp = now_r;
                end
              end
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    dev_r        <= dev_nxt;
    blk_r        <= blk_nxt;
    sidx_r       <= sidx_nxt;
    now_r        <= now_nxt;
    idx_r        <= idx_nxt;
    tgt_r        <= tgt_nxt;
    vic_r        <= vic_nxt;
    oldest_r     <= oldest_nxt;
    found_r      <= found_nxt;
    have_r       <= have_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hit_r    <= out_hit_nxt;
    out_fill_r   <= out_fill_nxt;
    out_status_r <= out_status_nxt;
  end

  // A new result is only ever produced by the update step.
  `BBC_ASSERT(a_result_from_update, clk, rst_n, $rose(out_valid_r) |-> $past(state_r) == S_UPDATE, "result appeared without an update step")

  // A get always starts its scan at the lowest slot.
  `BBC_ASSERT(a_scan_starts_low, clk, rst_n, in_fire && in_ch.opcode == OP_GET |=> state_r == S_SCAN && idx_r == '0, "get scan did not start at slot zero")

  // A store write happens only in the update step.
  `BBC_ASSERT_NEVER(a_write_outside_update, clk, rst_n, wr.en && state_r != S_UPDATE, "slot store written outside the update step")

  // A failed get never claims a hit or a fill.
  `BBC_ASSERT_NEVER(a_no_free_clean, clk, rst_n, out_valid_r && out_status_r == ST_NO_FREE && (out_hit_r || out_fill_r), "no-free result carries hit or fill")

endmodule

// ===== rtl/bbc_slot_store.sv =====
// Slot store of the buffer cache: tag, count, stamp and valid mark per slot,
// one read port and one write port. Depends on bbc_pkg.
module bbc_slot_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bbc_pkg::SLOT_W-1:0] rd_idx,
  output bbc_pkg::slot_entry_t      rd_entry,
  input  bbc_pkg::slot_wr_t         wr
);
  import bbc_pkg::*;

  slot_entry_t store_r [SLOT_COUNT];

  assign rd_entry = store_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        store_r[i] <= '0;
      end
    end else if (wr.en) begin
      store_r[wr.idx] <= wr.entry;
    end
  end

endmodule
